// ===== design/tpd_pkg.sv =====
// Package for the ternary packed dot product engine.
// Holds the command codes, weight codes, register indexes and the queue entry type.
// No dependencies.
`default_nettype none

package tpd_pkg;

  localparam int LANES       = 16;
  localparam int LANE_W      = 4;
  localparam int IDX_W       = 12;
  localparam int WP_W        = 8;
  localparam int ACC_W       = 34;
  localparam int LEN_W       = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [LEN_W-1:0] ACTIVE_LENGTH_RESET = 13'd4096;

  localparam logic [1:0] CODE_POS = 2'b01;
  localparam logic [1:0] CODE_NEG = 2'b10;

  localparam logic [0:0] REG_ACTIVE_LENGTH = 1'b0;
  localparam logic [0:0] REG_BIAS_ENABLE   = 1'b1;

  localparam logic [31:0] SUM_POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] SUM_NEG_LIMIT = 32'h8000_0000;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_WEIGHT = 1'b1
  } cmd_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    cmd_t               cmd;
    logic               load_ok;
    logic [IDX_W-1:0]   act_index;
    logic [31:0]        act_data;
    logic [31:0]        weight_word;
    logic               last_word;
    logic signed [31:0] bias_value;
  } q_entry_t;

  typedef struct packed {
    logic [LEN_W-1:0] active_length;
    logic             bias_enable;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ===== design/tpd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module tpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tpd_front.sv =====
// Front end: accepts requests and classifies them into queue entries.
// Depends on tpd_pkg.
`default_nettype none

module tpd_front #(
  parameter int MAX_LENGTH = 4096
) (
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic [11:0]          in_act_index,
  input  wire logic signed [15:0]   in_act_value,
  input  wire logic [31:0]          in_weight_word,
  input  wire logic                 in_last_word,
  input  wire logic signed [31:0]   in_bias_value,
  input  wire logic                 q_full,
  output logic                      push,
  output tpd_pkg::q_entry_t         push_entry
);

  import tpd_pkg::*;

  localparam logic [16:0] MAX_POS = 17'(MAX_LENGTH);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry.cmd         = cmd_t'(in_command);
    // Loads beyond the store are dropped later.
    push_entry.load_ok     = 17'(in_act_index) < MAX_POS;
    push_entry.act_index   = in_act_index;
    push_entry.act_data    = 32'(in_act_value);
    push_entry.weight_word = in_weight_word;
    push_entry.last_word   = in_last_word;
    push_entry.bias_value  = in_bias_value;
  end

endmodule

`default_nettype wire

// ===== design/tpd_queue.sv =====
// Short FIFO that decouples the front end from the execution back end.
// Depends on tpd_pkg.
`default_nettype none

module tpd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  tpd_pkg::q_entry_t      push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output tpd_pkg::q_entry_t      head_entry
);

  import tpd_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tpd_back.sv =====
// Back end: activation store, lane pipeline, accumulator, bias and saturation.
// Depends on tpd_pkg and tpd_ram.
`default_nettype none

module tpd_back #(
  parameter int MAX_LENGTH = 4096,
  parameter int ACT_WIDTH  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  tpd_pkg::q_entry_t         q_entry,
  output logic                      q_pop,
  input  tpd_pkg::cfg_regs_t        cfg,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_sum_value,
  output logic                      out_saturated
);

  import tpd_pkg::*;

  localparam int WORDS = (MAX_LENGTH + LANES - 1) / LANES;
  localparam int ROWS  = WORDS > (1 << WP_W) ? (1 << WP_W) : WORDS;
  localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int GW    = ACT_WIDTH + 3;
  localparam int PW    = ACT_WIDTH + 5;
  localparam int EW    = PW > ACC_W ? PW : ACC_W;
  localparam logic [16:0]     MAX_POS  = 17'(MAX_LENGTH);
  localparam logic [WP_W-1:0] LAST_ROW = WP_W'(ROWS - 1);

  logic                 en;
  logic                 is_weight;
  logic                 rd_req;
  logic [ACT_WIDTH-1:0] rd_data [LANES];
  logic [WP_W-1:0]      wp_r;

  logic                 s2_v_r;
  logic [31:0]          s2_codes_r;
  logic                 s2_last_r;
  logic signed [31:0]   s2_bias_r;
  logic [WP_W-1:0]      s2_row_r;

  logic signed [ACT_WIDTH:0] term [LANES];
  logic signed [GW-1:0]      grp [4];

  logic                 s3_v_r;
  logic signed [GW-1:0] s3_grp_r [4];
  logic                 s3_last_r;
  logic signed [31:0]   s3_bias_r;

  logic signed [PW-1:0] part;
  logic signed [EW-1:0] part_ext;
  logic [ACC_W-1:0]     acc_r;
  logic [ACC_W-1:0]     acc_sum;

  logic                    s4_v_r;
  logic signed [ACC_W-1:0] s4_total_r;
  logic signed [31:0]      s4_bias_r;

  logic signed [ACC_W:0] total;
  logic                  sat_hi;
  logic                  sat_lo;
  logic                  out_valid_r;

  // The whole back end advances together unless a finished result is held.
  assign en        = !(out_valid_r && out_stall);
  assign q_pop     = q_valid && en;
  assign is_weight = q_entry.cmd == CMD_WEIGHT;
  assign rd_req    = q_pop && is_weight;

  // The store is split into one RAM per lane, so all lanes of a word are read together.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tpd_ram #(
      .WIDTH (ACT_WIDTH),
      .DEPTH (ROWS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (q_pop && !is_weight && q_entry.load_ok &&
                q_entry.act_index[LANE_W-1:0] == LANE_W'(l)),
      .wr_addr (q_entry.act_index[ROW_W+LANE_W-1:LANE_W]),
      .wr_data (q_entry.act_data[ACT_WIDTH-1:0]),
      .rd_en   (rd_req),
      .rd_addr (wp_r[ROW_W-1:0]),
      .rd_data (rd_data[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (rd_req) begin
      if (q_entry.last_word || wp_r == LAST_ROW) begin
        wp_r <= '0;
      end else begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= rd_req;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_codes_r <= q_entry.weight_word;
      s2_last_r  <= q_entry.last_word;
      s2_bias_r  <= q_entry.bias_value;
      s2_row_r   <= wp_r;
    end
  end

  always_comb begin
    logic [IDX_W-1:0] pos;
    logic             keep;
    logic [1:0]       code;
    logic signed [ACT_WIDTH-1:0] a;
    for (int l = 0; l < LANES; l++) begin
      pos  = {s2_row_r, LANE_W'(l)};
      keep = (13'(pos) < cfg.active_length) && (17'(pos) < MAX_POS);
      code = s2_codes_r[2*l +: 2];
      a    = signed'(rd_data[l]);
      if (keep && code == CODE_POS) begin
        term[l] = (ACT_WIDTH + 1)'(a);
      end else if (keep && code == CODE_NEG) begin
        term[l] = -((ACT_WIDTH + 1)'(a));
      end else begin
        term[l] = '0;
      end
    end
    for (int g = 0; g < 4; g++) begin
      grp[g] = GW'(term[4*g]) + GW'(term[4*g+1]) + GW'(term[4*g+2]) + GW'(term[4*g+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        s3_grp_r[g] <= grp[g];
      end
      s3_last_r <= s2_last_r;
      s3_bias_r <= s2_bias_r;
    end
  end

  always_comb begin
    part     = PW'(s3_grp_r[0]) + PW'(s3_grp_r[1]) + PW'(s3_grp_r[2]) + PW'(s3_grp_r[3]);
    part_ext = EW'(part);
    acc_sum  = acc_r + part_ext[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r && s3_last_r;
      if (s3_v_r) begin
        acc_r <= s3_last_r ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_total_r <= signed'(acc_sum);
      s4_bias_r  <= s3_bias_r;
    end
  end

  always_comb begin
    total = (ACC_W + 1)'(s4_total_r);
    if (cfg.bias_enable) begin
      total = total + (ACC_W + 1)'(s4_bias_r);
    end
    sat_hi = !total[ACC_W] && (|total[ACC_W-1:31]);
    sat_lo = total[ACC_W] && !(&total[ACC_W-1:31]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_v_r) begin
      out_saturated <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_sum_value <= signed'(SUM_POS_LIMIT);
      end else if (sat_lo) begin
        out_sum_value <= signed'(SUM_NEG_LIMIT);
      end else begin
        out_sum_value <= signed'(total[31:0]);
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/ternary_packed_dot_product.sv =====
// Top level of the ternary packed dot product engine.
// Depends on tpd_pkg, tpd_front, tpd_queue, tpd_back (and tpd_ram below it).
//
//   Channel   Direction  Handshake            Carries
//   in_       input      in_valid / in_stall  command, activation load, weight word, bias
//   out_      output     out_valid/out_stall  saturated sum and saturation flag
//   cfg_      input      cfg_wr_en            active_length (index 0), bias_enable (index 1)
//
// One request is taken every cycle unless in_stall; a sum passes s2, s3, s4 and out regs.
// The rate is set by the lane RAMs, which read all sixteen activations of a word at once.
// The back end stalls as a whole while a result waits; the two-entry queue then fills.
// Synchronous active-low reset zeroes the accumulator and word position and resets config.
// The activation store is not cleared: an entry must be loaded before any word uses it.
`default_nettype none

module ternary_packed_dot_product #(
  parameter int MAX_LENGTH = 4096,
  parameter int ACT_WIDTH  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic [11:0]          in_act_index,
  input  wire logic signed [15:0]   in_act_value,
  input  wire logic [31:0]          in_weight_word,
  input  wire logic                 in_last_word,
  input  wire logic signed [31:0]   in_bias_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_sum_value,
  output logic                      out_saturated,
  input  wire logic                 cfg_wr_en,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [12:0]          cfg_wr_data
);

  import tpd_pkg::*;

  logic [LEN_W-1:0] active_len_r;
  logic             bias_enable_r;
  cfg_regs_t        cfg;
  logic             push;
  q_entry_t         push_entry;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  q_entry_t         q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_len_r  <= ACTIVE_LENGTH_RESET;
      bias_enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ACTIVE_LENGTH: active_len_r  <= cfg_wr_data;
        REG_BIAS_ENABLE:   bias_enable_r <= cfg_wr_data[0];
        default:           active_len_r  <= active_len_r;
      endcase
    end
  end

  assign cfg.active_length = active_len_r;
  assign cfg.bias_enable   = bias_enable_r;

  tpd_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_act_index   (in_act_index),
    .in_act_value   (in_act_value),
    .in_weight_word (in_weight_word),
    .in_last_word   (in_last_word),
    .in_bias_value  (in_bias_value),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  tpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  tpd_back #(
    .MAX_LENGTH (MAX_LENGTH),
    .ACT_WIDTH  (ACT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (q_head),
    .q_pop         (q_pop),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sum_value (out_sum_value),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire
